@@ hw/rtl/mab_pkg.sv @@
// Shared types, codes and constants of the multi-area bump allocator.
package mab_pkg;

    localparam int DATA_W      = 32;
    localparam int TOTAL_W     = 36;
    localparam int PADDR_W     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] INIT_REGION_RESET = 32'd65536;

    // register index taken from paddr[2]
    localparam logic REG_INIT_REGION = 1'b0;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] request_size;
        logic [4:0]  align_log2;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  area_index;
        logic [31:0] offset;
        logic        area_added;
        logic        fits;
        logic [35:0] total_used;
    } out_item_t;

    // classified item as handed from the front part to the back part
    typedef enum logic [2:0] {
        K_ALLOC = 3'd0,
        K_PROBE = 3'd1,
        K_CLEAR = 3'd2,
        K_NOP   = 3'd3,
        K_OVER  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] aligned;
    } job_t;

endpackage

@@ hw/rtl/multi_area_bump_allocator.sv @@
// Bump allocator over a table of areas: request front end, queue, scan engine, APB register.
//
// Requests enter on req (valid/ready) and each produces exactly one result on rsp
// (valid/ready), in order. A request is aligned and classified in the front register,
// waits in a two-entry queue, then the back engine scans the areas in creation order.
// Each area inspected passes through a table read state and a compare state on the single read port.
// In the back engine an allocation that places goes through the scan, then S_WRITE or S_APPEND,
// then S_DONE; a probe or a table-full answer goes from the scan to S_DONE. The scan inspects
// at most MAX_AREAS areas. Clear, oversize and unused commands go from S_IDLE to S_DONE. The front
// register and the queue keep taking up to three items while the engine works or a result waits.
// A result held by a stalled receiver stays in the output register; the engine may
// finish the next item meanwhile and then waits for the register to free up.
// After reset there is one area whose capacity is initial_region_size (65536 at
// reset), all fills read as zero and the grown region size is zero. The area table is
// not cleared; per-area valid bits stand in for the fill reset.
// initial_region_size is at APB address 0 and should only be written while idle.
module multi_area_bump_allocator #(
    parameter int MAX_AREAS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  mab_pkg::in_item_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output mab_pkg::out_item_t                  rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mab_pkg::PADDR_W-1:0]         paddr,
    input  logic [mab_pkg::DATA_W-1:0]          pwdata,
    output logic [mab_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import mab_pkg::*;

    logic        init_region_sel;
    logic [31:0] init_region_reg;
    logic [31:0] init_region_next;
    logic        cfg_wr;
    logic        q_push;
    job_t        q_push_data;
    logic        q_full;
    logic        q_pop;
    job_t        q_pop_data;
    logic        q_empty;

    assign pready          = 1'b1;
    assign init_region_sel = (paddr[2] == REG_INIT_REGION);
    assign cfg_wr          = psel && penable && pwrite && init_region_sel;
    assign init_region_next = cfg_wr ? pwdata : init_region_reg;
    assign prdata          = init_region_sel ? init_region_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_region_reg <= INIT_REGION_RESET;
        end
        else
        begin
            init_region_reg <= init_region_next;
        end
    end

    mab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    mab_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    mab_back #(
        .MAX_AREAS (MAX_AREAS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .pop         (q_pop),
        .pop_data    (q_pop_data),
        .region_init (init_region_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

@@ hw/rtl/mab_front.sv @@
// Front part: accepts request items, aligns the size and classifies them.
module mab_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mab_pkg::in_item_t req,
    output logic              push,
    output mab_pkg::job_t     push_data,
    input  logic              full
);
    import mab_pkg::*;

    logic        stage_valid_reg;
    logic        stage_valid_next;
    job_t        stage_reg;
    job_t        stage_next;
    logic [32:0] amask;
    logic [32:0] rounded;
    logic [32:0] aligned;
    logic        oversize;

    // round up to 2^align_log2 in 33 bits; bit 32 set means it no longer fits
    always_comb
    begin
        amask    = (33'd1 << req.align_log2) - 33'd1;
        rounded  = {1'b0, req.request_size} + amask;
        aligned  = rounded & ~amask;
        oversize = aligned[32];
    end

    always_comb
    begin
        stage_next.aligned = aligned[31:0];
        case (req.cmd)
            CMD_ALLOC: stage_next.kind = oversize ? K_OVER : K_ALLOC;
            CMD_PROBE: stage_next.kind = oversize ? K_OVER : K_PROBE;
            CMD_CLEAR: stage_next.kind = K_CLEAR;
            default:   stage_next.kind = K_NOP;
        endcase
    end

    assign push      = stage_valid_reg && !full;
    assign push_data = stage_reg;
    assign req_ready = !stage_valid_reg || !full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req_valid && req_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ hw/rtl/mab_queue.sv @@
// Short queue of classified items between the front and back parts.
module mab_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mab_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output mab_pkg::job_t pop_data,
    output logic          empty
);
    import mab_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/mab_back.sv @@
// Back part: first-fit scan over the area table, fill update, area append, result register.
module mab_back #(
    parameter int MAX_AREAS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    output logic               pop,
    input  mab_pkg::job_t      pop_data,
    input  logic [31:0]        region_init,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mab_pkg::out_item_t rsp
);
    import mab_pkg::*;

    localparam int IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int CNT_W = $clog2(MAX_AREAS + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_WRITE  = 6'b001000,
        S_APPEND = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    job_t                 job_reg;
    job_t                 job_next;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     scan_idx_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [31:0]          grown_reg;
    logic [31:0]          grown_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic [MAX_AREAS-1:0] fill_vld_reg;
    logic [MAX_AREAS-1:0] fill_vld_next;
    out_item_t            res_reg;
    out_item_t            res_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_reg;
    out_item_t            out_next;

    logic [31:0]          cap_mem  [MAX_AREAS];
    logic [31:0]          fill_mem [MAX_AREAS];
    logic [31:0]          cap_rd_reg;
    logic [31:0]          fill_rd_reg;
    logic                 fill_vld_rd_reg;

    logic                 cap_we;
    logic                 fill_we;
    logic [IDX_W-1:0]     wr_idx;
    logic [31:0]          cap_wdata;
    logic [31:0]          fill_wdata;

    logic [31:0]          cap_cur;
    logic [31:0]          fill_cur;
    logic [32:0]          need;
    logic                 area_fits;
    logic                 last_area;
    logic                 table_full;
    logic [31:0]          region_base;
    logic [31:0]          region_new;

    // area 0 follows the configuration register live; an uncleared fill reads as zero
    assign cap_cur    = (scan_idx_reg == '0) ? region_init : cap_rd_reg;
    assign fill_cur   = fill_vld_rd_reg ? fill_rd_reg : '0;
    assign need       = {1'b0, fill_cur} + {1'b0, job_reg.aligned};
    assign area_fits  = (job_reg.aligned == '0) || (need <= {1'b0, cap_cur});
    assign last_area  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(MAX_AREAS));

    assign region_base = (grown_reg > region_init) ? grown_reg : region_init;
    assign region_new  = (region_base < job_reg.aligned) ? job_reg.aligned : region_base;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        scan_idx_next  = scan_idx_reg;
        count_next     = count_reg;
        grown_next     = grown_reg;
        total_next     = total_reg;
        fill_vld_next  = fill_vld_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        cap_we         = 1'b0;
        fill_we        = 1'b0;
        wr_idx         = scan_idx_reg;
        cap_wdata      = region_new;
        fill_wdata     = res_reg.offset + job_reg.aligned;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop           = 1'b1;
                    job_next      = pop_data;
                    res_next      = '0;
                    scan_idx_next = '0;
                    case (pop_data.kind)
                        K_CLEAR:
                        begin
                            fill_vld_next = '0;
                            total_next    = '0;
                            state_next    = S_DONE;
                        end
                        K_OVER:
                        begin
                            res_next.status = ST_OVERSIZE;
                            state_next      = S_DONE;
                        end
                        K_ALLOC, K_PROBE:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (area_fits)
                begin
                    if (job_reg.kind == K_PROBE)
                    begin
                        res_next.fits = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        res_next.area_index = 4'(scan_idx_reg);
                        res_next.offset     = fill_cur;
                        state_next          = S_WRITE;
                    end
                end
                else if (!last_area)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    state_next    = S_READ;
                end
                else if (job_reg.kind == K_PROBE)
                begin
                    state_next = S_DONE;
                end
                else if (table_full)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_WRITE:
            begin
                fill_we               = 1'b1;
                fill_vld_next[wr_idx] = 1'b1;
                total_next            = total_reg + TOTAL_W'(job_reg.aligned);
                state_next            = S_DONE;
            end
            S_APPEND:
            begin
                // new area starts empty, so its fill becomes the aligned size
                cap_we                = 1'b1;
                fill_we               = 1'b1;
                wr_idx                = count_reg[IDX_W-1:0];
                fill_wdata            = job_reg.aligned;
                fill_vld_next[wr_idx] = 1'b1;
                grown_next            = region_new;
                count_next            = count_reg + CNT_W'(1);
                total_next            = total_reg + TOTAL_W'(job_reg.aligned);
                res_next.area_index   = 4'(count_reg);
                res_next.offset       = '0;
                res_next.area_added   = 1'b1;
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next            = res_reg;
                    out_next.total_used = total_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            grown_reg     <= '0;
            total_reg     <= '0;
            fill_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            grown_reg     <= grown_next;
            total_reg     <= total_next;
            fill_vld_reg  <= fill_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        scan_idx_reg <= scan_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // area table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[wr_idx] <= cap_wdata;
        end
        if (fill_we)
        begin
            fill_mem[wr_idx] <= fill_wdata;
        end
        cap_rd_reg      <= cap_mem[scan_idx_reg];
        fill_rd_reg     <= fill_mem[scan_idx_reg];
        fill_vld_rd_reg <= fill_vld_reg[scan_idx_reg];
    end

endmodule

@@ hw/rtl/mab_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
module mab_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input mab_pkg::out_item_t          rsp,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mab_pkg::PADDR_W-1:0] paddr,
    input logic [mab_pkg::DATA_W-1:0]  pwdata,
    input logic [mab_pkg::DATA_W-1:0]  prdata
);
    import mab_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // failed requests carry no placement
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.offset == '0) && !rsp.area_added && !rsp.fits && (rsp.area_index == '0))
        else $error("failed request reports a placement");

    // a probe answer never reports an allocation
    a_probe_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fits |->
            (rsp.offset == '0) && !rsp.area_added && (rsp.area_index == '0))
        else $error("probe answer carries allocation fields");

    // an appended area starts at offset zero
    a_added_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.area_added |-> (rsp.offset == '0) && (rsp.area_index != '0))
        else $error("appended area reports a nonzero offset");

    // the region register reads back what was written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == REG_INIT_REGION) |=>
            (paddr[2] != REG_INIT_REGION) || (prdata == $past(pwdata)))
        else $error("region register readback mismatch");

endmodule

bind multi_area_bump_allocator mab_checker u_mab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

@@ tb/multi_area_bump_allocator_chk.sv @@
// Checker for the bump allocator: tracks the area table, predicts each result and compares.
module multi_area_bump_allocator_chk
    import mab_pkg::*;
#(
    parameter int MAX_AREAS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  in_item_t            req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  out_item_t           rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  error_count,
    output int                  outstanding,
    output int                  checked_count,
    output int                  appended_count,
    output int                  full_count,
    output int                  oversize_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] region_base;
    logic [31:0] cap_tbl [MAX_AREAS];
    logic [31:0] fill_tbl [MAX_AREAS];
    int unsigned n_areas;
    logic [31:0] grown_size;
    out_item_t   predicted_results [$];

    // area 0 follows the register live, the others keep the capacity they were given
    function automatic logic [31:0] room_in(input int unsigned a);
        logic [31:0] c;
        c = (a == 0) ? region_base : cap_tbl[a];
        return (c > fill_tbl[a]) ? c - fill_tbl[a] : 32'd0;
    endfunction

    function automatic int unsigned first_fitting(input logic [63:0] need);
        int unsigned a;
        for (a = 0; a < n_areas && a < MAX_AREAS; a++)
            if ({32'd0, room_in(a)} >= need)
                return a;
        return n_areas;
    endfunction

    function automatic out_item_t step_allocator(input in_item_t it);
        out_item_t   r;
        logic [63:0] mask;
        logic [63:0] sized;
        logic [31:0] cap_new;
        logic [35:0] sum;
        int unsigned a;
        r     = '0;
        mask  = (64'd1 << it.align_log2) - 64'd1;
        sized = ({32'd0, it.request_size} + mask) & ~mask;
        if (it.cmd == CMD_CLEAR)
        begin
            for (a = 0; a < MAX_AREAS; a++)
                fill_tbl[a] = '0;
        end
        else if (it.cmd == CMD_ALLOC || it.cmd == CMD_PROBE)
        begin
            if (sized > 64'hFFFF_FFFF)
                r.status = ST_OVERSIZE;
            else if (it.cmd == CMD_PROBE)
                r.fits = (first_fitting(sized) < n_areas);
            else
            begin
                a = first_fitting(sized);
                if (a >= n_areas)
                begin
                    if (n_areas >= MAX_AREAS)
                        r.status = ST_FULL;
                    else
                    begin
                        cap_new = (grown_size > region_base) ? grown_size : region_base;
                        if (cap_new < sized[31:0])
                            cap_new = sized[31:0];
                        grown_size   = cap_new;
                        cap_tbl[a]   = cap_new;
                        fill_tbl[a]  = '0;
                        n_areas      = a + 1;
                        r.area_added = 1'b1;
                    end
                end
                if (r.status == ST_OK)
                begin
                    r.area_index = a[3:0];
                    r.offset     = fill_tbl[a];
                    fill_tbl[a]  = fill_tbl[a] + sized[31:0];
                end
            end
        end
        sum = '0;
        for (a = 0; a < n_areas && a < MAX_AREAS; a++)
            sum = sum + {4'd0, fill_tbl[a]};
        r.total_used = sum;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [35:0] want,
                               input logic [35:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, checked_count, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t   want;
        int unsigned a;
        if (!rst_n)
        begin
            region_base = INIT_REGION_RESET;
            for (a = 0; a < MAX_AREAS; a++)
            begin
                cap_tbl[a]  = '0;
                fill_tbl[a] = '0;
            end
            n_areas    = 1;
            grown_size = '0;
            predicted_results.delete();
            error_count    = 0;
            outstanding    = 0;
            checked_count  = 0;
            appended_count = 0;
            full_count     = 0;
            oversize_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_INIT_REGION)
                region_base = pwdata;
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result 0x%0h, expected none", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", 36'(want.status), 36'(rsp.status));
                    check_field("area_index", 36'(want.area_index), 36'(rsp.area_index));
                    check_field("offset", 36'(want.offset), 36'(rsp.offset));
                    check_field("area_added", 36'(want.area_added), 36'(rsp.area_added));
                    check_field("fits", 36'(want.fits), 36'(rsp.fits));
                    check_field("total_used", want.total_used, rsp.total_used);
                    checked_count++;
                    if (want.area_added)
                        appended_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                    if (want.status == ST_OVERSIZE)
                        oversize_count++;
                end
            end
            if (req_valid && req_ready)
                predicted_results.push_back(step_allocator(req));
            outstanding = predicted_results.size();
        end
    end

endmodule

@@ tb/multi_area_bump_allocator_tb.sv @@
// Testbench top for the bump allocator: clock, reset, request and register stimulus, verdict.
module multi_area_bump_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mab_pkg::*;

    localparam int MAX_AREAS       = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 194;
    localparam int SETTLE_CYCLES   = 80;

    localparam logic [1:0]         CMD_UNUSED       = 2'd3;
    localparam logic [PADDR_W-1:0] INIT_REGION_ADDR = {REG_INIT_REGION, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    in_item_t            req;
    logic                rsp_valid;
    logic                rsp_ready;
    out_item_t           rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int error_count;
    int outstanding;
    int checked_count;
    int appended_count;
    int full_count;
    int oversize_count;

    int n_alloc;
    int n_probe;
    int n_clear;
    int n_unused;
    int n_writes;
    bit calm;   // both sides run without idling while set

    always #4 clk = ~clk;

    multi_area_bump_allocator #(.MAX_AREAS(MAX_AREAS)) i_dut (.*);

    multi_area_bump_allocator_chk #(.MAX_AREAS(MAX_AREAS)) i_chk (.*);

    task automatic issue(input logic [1:0] c, input logic [31:0] size, input logic [4:0] al);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid        <= 1'b1;
        req.cmd          <= c;
        req.request_size <= size;
        req.align_log2   <= al;
        do
            @(posedge clk);
        while (!req_ready);
        case (c)
            CMD_ALLOC: n_alloc++;
            CMD_PROBE: n_probe++;
            CMD_CLEAR: n_clear++;
            default:   n_unused++;
        endcase
    endtask

    // heavy phases favour big requests and rare clears so the table fills up
    task automatic issue_random(input bit heavy);
        int unsigned pick;
        logic [1:0]  c;
        logic [31:0] size;
        logic [4:0]  al;
        pick = $urandom_range(0, 99);
        if (pick < 64)
            c = CMD_ALLOC;
        else if (pick < 92)
            c = CMD_PROBE;
        else if (pick < (heavy ? 93 : 96))
            c = CMD_CLEAR;
        else if (pick < 96)
            c = CMD_ALLOC;
        else
            c = CMD_UNUSED;
        pick = $urandom_range(0, 99);
        if (heavy && pick < 40)
            size = $urandom;
        else if (pick < 45)
            size = $urandom_range(0, 63);
        else if (pick < 75)
            size = $urandom_range(0, 1023);
        else if (pick < 90)
            size = $urandom_range(0, 65535);
        else if (pick < 97)
            size = $urandom;
        else
            size = 32'hFFFF_FFFF - $urandom_range(0, 255);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            al = 5'($urandom_range(0, 4));
        else if (pick < 95)
            al = 5'($urandom_range(5, 16));
        else
            al = 5'($urandom_range(17, 31));
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        issue(c, size, al);
    endtask

    // hold the request side until every predicted result has been taken
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_region(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INIT_REGION_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    // result side: random stall per item, with calm stretches
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin
        logic [31:0] region_plan [PHASES];
        int          target;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        calm      = 1'b0;
        region_plan = '{32'd1, 32'hFFFF_FFFF, 32'd64, 32'd4096, 32'd0,
                        32'hFFFF_FFFF, 32'd1, 32'd65536};
        region_plan[4] = $urandom_range(2, 32'hFFFF_FFFE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value region: zero sizes, alignment rounding, growth, oversize, unused command
        issue(CMD_PROBE, 32'd0, 5'd0);
        issue(CMD_ALLOC, 32'd0, 5'd0);
        issue(CMD_ALLOC, 32'd1, 5'd0);
        issue(CMD_ALLOC, 32'd5, 5'd3);
        issue(CMD_ALLOC, 32'd0, 5'd16);
        issue(CMD_ALLOC, 32'd1, 5'd16);
        issue(CMD_PROBE, 32'd65536, 5'd0);
        issue(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);
        issue(CMD_ALLOC, 32'hFFFF_FFFF, 5'd1);
        issue(CMD_PROBE, 32'h8000_0001, 5'd31);
        issue(CMD_PROBE, 32'd1, 5'd31);
        issue(CMD_CLEAR, 32'd0, 5'd0);
        issue(CMD_ALLOC, 32'd70000, 5'd0);
        issue(CMD_PROBE, 32'd65536, 5'd0);
        settle();
        write_region(32'd1);
        issue(CMD_ALLOC, 32'd1, 5'd0);
        issue(CMD_ALLOC, 32'd2, 5'd1);
        issue(CMD_PROBE, 32'd1, 5'd0);
        issue(CMD_CLEAR, 32'd0, 5'd0);
        settle();
        write_region(32'hFFFF_FFFF);
        issue(CMD_ALLOC, 32'hFFFF_FFFF, 5'd0);
        issue(CMD_ALLOC, 32'd0, 5'd31);
        // shrinking the region leaves area 0 filled past its capacity
        settle();
        write_region(32'd16);
        issue(CMD_PROBE, 32'd1, 5'd0);
        issue(CMD_ALLOC, 32'd16, 5'd4);
        issue(CMD_CLEAR, 32'd0, 5'd0);
        issue(CMD_ALLOC, 32'd17, 5'd0);

        target = n_alloc + n_probe + n_clear + n_unused;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_region(region_plan[p]);
            target += ITEMS_PER_PHASE;
            while (n_alloc + n_probe + n_clear + n_unused < target)
                issue_random(p % 2 == 1);
        end

        calm = 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Summary: %0d results checked from %0d allocations, %0d probes, %0d clears,",
                 checked_count, n_alloc, n_probe, n_clear);
        $display("         %0d unused commands and %0d region writes; %0d areas appended, "
                 , n_unused, n_writes, appended_count);
        $display("         %0d table-full and %0d oversize answers.", full_count, oversize_count);
        if (outstanding != 0)
            $display("%0t: %0d predicted results never arrived", $time, outstanding);
        if (error_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: run timed out", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
